// ===== rtl/rtt_pkg.sv =====
package rtt_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_DELETED  = 3'd2,
    KIND_NOTFOUND = 3'd3,
    KIND_FIRED    = 3'd4
  } kind_e;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] action;
    logic [31:0] interval;
    logic [15:0] limit;
    logic [15:0] count;
    logic [31:0] last_time;
  } slot_word_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== rtl/rtt_ram.sv =====
module rtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rtt_ctrl.sv =====
module rtt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  rtt_pkg::dp_stat_t  stat_i,
  output rtt_pkg::ctrl_cmd_t cmd_o
);
  import rtt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cmd_o.load  = start_i && (state_q == ST_IDLE);
  assign cmd_o.scan  = (state_q == ST_SCAN);
  assign cmd_o.flush = (state_q == ST_FLUSH);

endmodule

// ===== rtl/rtt_datapath.sv =====
module rtt_datapath #(
  parameter int unsigned SLOTS = rtt_pkg::SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtt_pkg::ctrl_cmd_t cmd_i,
  output rtt_pkg::dp_stat_t  stat_o,
  input  logic [1:0]         command_i,
  input  logic [15:0]        tag_i,
  input  logic [15:0]        action_i,
  input  logic [31:0]        interval_ms_i,
  input  logic [15:0]        repeat_limit_i,
  input  logic [31:0]        now_ms_i,
  output logic               result_strobe_o,
  output logic [2:0]         kind_o,
  output logic [3:0]         slot_o,
  output logic [15:0]        fired_tag_o,
  output logic [15:0]        fired_action_o,
  output logic               retired_o,
  output logic               last_o
);
  import rtt_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned WW = $bits(slot_word_t);

  // latched item
  logic [1:0]  command_q;
  logic [15:0] tag_q, action_q, limit_q;
  logic [31:0] interval_q, now_q;

  // scan pipeline
  logic [CW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [IW-1:0]          eval_ptr_q;
  logic                   eval_vld_q, eval_vld_d;
  logic [SLOTS-1:0]       used_q, used_d;
  logic [FIRE_CNT_W-1:0]  nfire_q, nfire_d;
  logic                   rd_en;

  // pending result, held until we know whether it is the final one
  logic        pend_vld_q, pend_vld_d;
  logic [2:0]  pend_kind_q, pend_kind_d;
  logic [3:0]  pend_slot_q, pend_slot_d;
  logic [15:0] pend_tag_q, pend_tag_d;
  logic [15:0] pend_action_q, pend_action_d;
  logic        pend_retired_q, pend_retired_d;

  logic        out_vld_q, out_vld_d;
  logic [2:0]  out_kind_q, out_kind_d;
  logic [3:0]  out_slot_q, out_slot_d;
  logic [15:0] out_tag_q, out_tag_d;
  logic [15:0] out_action_q, out_action_d;
  logic        out_retired_q, out_retired_d;
  logic        out_last_q, out_last_d;

  slot_word_t rd_word, wr_word;
  logic       we;

  logic        ev, used_e, is_last;
  logic        add_hit, del_hit, tick_hit, due, retire, cap, stop;
  logic [32:0] due_at;
  logic [15:0] cnt_nx;

  assign rd_en = cmd_i.scan && (rd_ptr_q < CW'(SLOTS));

  rtt_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (eval_ptr_q),
    .wdata_i (wr_word),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q[IW-1:0]),
    .rdata_o (rd_word)
  );

  always_comb begin
    ev       = cmd_i.scan && eval_vld_q;
    used_e   = used_q[eval_ptr_q];
    is_last  = (eval_ptr_q == IW'(SLOTS - 1));
    due_at   = {1'b0, rd_word.last_time} + {1'b0, rd_word.interval};
    due      = used_e && ({1'b0, now_q} >= due_at);
    cnt_nx   = rd_word.count + 16'd1;
    retire   = (rd_word.limit != 16'd0) && (cnt_nx == rd_word.limit);
    cap      = (nfire_q == FIRE_CNT_W'(MAX_RESULTS - 1));
    add_hit  = ev && (command_q == CMD_ADD) && !used_e;
    del_hit  = ev && (command_q == CMD_DEL) && used_e && (rd_word.tag == tag_q);
    tick_hit = ev && (command_q == CMD_TICK) && due;
    // a finite timer firing or the result cap ends a tick early
    stop     = add_hit || del_hit || (tick_hit && ((rd_word.limit != 16'd0) || cap))
               || (ev && is_last);
  end

  assign stat_o.scan_done = stop;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    eval_vld_d = 1'b0;
    used_d     = used_q;
    nfire_d    = nfire_q;
    we         = 1'b0;
    wr_word    = rd_word;

    pend_vld_d     = pend_vld_q;
    pend_kind_d    = pend_kind_q;
    pend_slot_d    = pend_slot_q;
    pend_tag_d     = pend_tag_q;
    pend_action_d  = pend_action_q;
    pend_retired_d = pend_retired_q;

    out_vld_d     = 1'b0;
    out_kind_d    = pend_kind_q;
    out_slot_d    = pend_slot_q;
    out_tag_d     = pend_tag_q;
    out_action_d  = pend_action_q;
    out_retired_d = pend_retired_q;
    out_last_d    = 1'b1;

    if (cmd_i.load) begin
      rd_ptr_d   = '0;
      nfire_d    = '0;
      pend_vld_d = 1'b0;
    end

    if (rd_en) begin
      rd_ptr_d   = rd_ptr_q + CW'(1);
      eval_vld_d = 1'b1;
    end

    if (add_hit) begin
      we                = 1'b1;
      wr_word.tag       = tag_q;
      wr_word.action    = action_q;
      wr_word.interval  = interval_q;
      wr_word.limit     = limit_q;
      wr_word.count     = 16'd0;
      wr_word.last_time = now_q;
      used_d[eval_ptr_q] = 1'b1;
      pend_vld_d     = 1'b1;
      pend_kind_d    = KIND_ADDED;
      pend_slot_d    = 4'(eval_ptr_q);
      pend_tag_d     = tag_q;
      pend_action_d  = 16'd0;
      pend_retired_d = 1'b0;
    end else if (del_hit) begin
      used_d[eval_ptr_q] = 1'b0;
      pend_vld_d     = 1'b1;
      pend_kind_d    = KIND_DELETED;
      pend_slot_d    = 4'(eval_ptr_q);
      pend_tag_d     = tag_q;
      pend_action_d  = 16'd0;
      pend_retired_d = 1'b0;
    end else if (tick_hit) begin
      we                = 1'b1;
      wr_word.count     = cnt_nx;
      wr_word.last_time = now_q;
      if (retire) used_d[eval_ptr_q] = 1'b0;
      nfire_d = nfire_q + FIRE_CNT_W'(1);
      // an earlier fire is now known not to be the final word
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_last_d = 1'b0;
      end
      pend_vld_d     = 1'b1;
      pend_kind_d    = KIND_FIRED;
      pend_slot_d    = 4'(eval_ptr_q);
      pend_tag_d     = rd_word.tag;
      pend_action_d  = rd_word.action;
      pend_retired_d = retire;
    end else if (ev && is_last &&
                 ((command_q == CMD_ADD) || (command_q == CMD_DEL))) begin
      pend_vld_d     = 1'b1;
      pend_kind_d    = (command_q == CMD_ADD) ? KIND_FULL : KIND_NOTFOUND;
      pend_slot_d    = 4'd0;
      pend_tag_d     = tag_q;
      pend_action_d  = 16'd0;
      pend_retired_d = 1'b0;
    end

    if (cmd_i.flush) begin
      out_vld_d  = pend_vld_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      eval_vld_q <= 1'b0;
      used_q     <= '0;
      nfire_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      eval_vld_q <= eval_vld_d;
      used_q     <= used_d;
      nfire_q    <= nfire_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q  <= command_i;
      tag_q      <= tag_i;
      action_q   <= action_i;
      interval_q <= interval_ms_i;
      limit_q    <= repeat_limit_i;
      now_q      <= now_ms_i;
    end
    eval_ptr_q     <= rd_ptr_q[IW-1:0];
    pend_kind_q    <= pend_kind_d;
    pend_slot_q    <= pend_slot_d;
    pend_tag_q     <= pend_tag_d;
    pend_action_q  <= pend_action_d;
    pend_retired_q <= pend_retired_d;
    out_kind_q     <= out_kind_d;
    out_slot_q     <= out_slot_d;
    out_tag_q      <= out_tag_d;
    out_action_q   <= out_action_d;
    out_retired_q  <= out_retired_d;
    out_last_q     <= out_last_d;
  end

  assign result_strobe_o = out_vld_q;
  assign kind_o          = out_kind_q;
  assign slot_o          = out_slot_q;
  assign fired_tag_o     = out_tag_q;
  assign fired_action_o  = out_action_q;
  assign retired_o       = out_retired_q;
  assign last_o          = out_last_q;

endmodule

// ===== rtl/repeating_timer_table_core.sv =====
// channel   direction  handshake                  payload
// command   in         start high, busy low       command_i tag_i action_i interval_ms_i
//                                                 repeat_limit_i now_ms_i
// result    out        result_strobe_o, 1 cycle   kind_o slot_o fired_tag_o fired_action_o
//                                                 retired_o last_o
//
// every command walks the slot memory one slot per cycle (one registered read port),
// and a hit can end the walk early
// a tick strobes one word per slot that fires; last_o rides on its final word
// reset clears the used flags but not the slot memory; slot contents are written by add before use
// results go out unconditionally, the receiver cannot stall
module repeating_timer_table_core #(
  parameter int unsigned SLOTS = rtt_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] tag_i,
  input  logic [15:0] action_i,
  input  logic [31:0] interval_ms_i,
  input  logic [15:0] repeat_limit_i,
  input  logic [31:0] now_ms_i,
  output logic        result_strobe_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [15:0] fired_tag_o,
  output logic [15:0] fired_action_o,
  output logic        retired_o,
  output logic        last_o
);
  import rtt_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  rtt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (dp_stat),
    .cmd_o   (ctrl_cmd)
  );

  rtt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .command_i       (command_i),
    .tag_i           (tag_i),
    .action_i        (action_i),
    .interval_ms_i   (interval_ms_i),
    .repeat_limit_i  (repeat_limit_i),
    .now_ms_i        (now_ms_i),
    .result_strobe_o (result_strobe_o),
    .kind_o          (kind_o),
    .slot_o          (slot_o),
    .fired_tag_o     (fired_tag_o),
    .fired_action_o  (fired_action_o),
    .retired_o       (retired_o),
    .last_o          (last_o)
  );

endmodule
